@@ src/assert_macros.svh @@
// Assertion macros shared by the console RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/txcon_pkg.sv @@
// Types and constants for the text console cell writer.
// Used by the controller, the datapath and the top level.
package txcon_pkg;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int POS_W  = 13;
  localparam int CELL_W = 16;
  localparam int CH_W   = 8;
  localparam int KIND_W = 3;

  localparam logic [CH_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CH_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [KIND_W-1:0] KIND_PUT      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEWLINE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_ATTR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

  typedef enum logic [2:0] {
    CLS_PUT,
    CLS_NEWLINE,
    CLS_CLEAR,
    CLS_SET_ATTR,
    CLS_READ,
    CLS_NONE
  } item_cls_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_CHAR,
    EM_CR,
    EM_LF
  } emit_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_NEWLINE,
    ST_SCROLL,
    ST_FILL_ROW,
    ST_CLEAR,
    ST_READ,
    ST_EM_PLAIN,
    ST_EM_CHAR_END,
    ST_EM_CHAR,
    ST_EM_CR,
    ST_EM_LF
  } state_t;

  typedef struct packed {
    logic  load_item;
    logic  put_write;
    logic  col_inc;
    logic  newline_step;
    logic  attr_load;
    logic  home;
    logic  ptr_zero;
    logic  scroll_step;
    logic  fill_step;
    logic  read_capture;
    logic  emit_load;
    emit_t emit_sel;
    logic  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    item_cls_t cls;
    logic      wrap;
    logic      bottom;
    logic      scroll_end;
    logic      fill_end;
    logic      out_free;
  } dp_status_t;

endpackage

@@ src/txcon_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module txcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/txcon_ctrl.sv @@
// Sequencer for the text console: walks each request through its steps.
// Depends on txcon_pkg and assert_macros.svh.
`include "assert_macros.svh"

module txcon_ctrl
  import txcon_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  state_t after_nl;

  // Ordinary put that wrapped still owes its character before CR and LF.
  assign after_nl = (st.cls == CLS_PUT) ? ST_EM_CHAR : ST_EM_CR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.emit_sel = EM_NONE;
    item_stall   = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        if (st.fill_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (st.cls)
          CLS_PUT:     state_next = ST_PUT;
          CLS_NEWLINE: state_next = ST_NEWLINE;
          CLS_CLEAR: begin
            cmd.attr_load = 1'b1;
            cmd.home      = 1'b1;
            cmd.ptr_zero  = 1'b1;
            state_next    = ST_CLEAR;
          end
          CLS_SET_ATTR: begin
            cmd.attr_load = 1'b1;
            state_next    = ST_EM_PLAIN;
          end
          CLS_READ:    state_next = ST_READ;
          default:     state_next = ST_EM_PLAIN;
        endcase
      end
      ST_PUT: begin
        cmd.put_write = 1'b1;
        if (st.wrap) begin
          state_next = ST_NEWLINE;
        end else begin
          cmd.col_inc = 1'b1;
          state_next  = ST_EM_CHAR_END;
        end
      end
      ST_NEWLINE: begin
        cmd.newline_step = 1'b1;
        if (st.bottom) begin
          cmd.ptr_zero = 1'b1;
          state_next   = ST_SCROLL;
        end else begin
          state_next = after_nl;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (st.scroll_end) begin
          state_next = ST_FILL_ROW;
        end
      end
      ST_FILL_ROW: begin
        cmd.fill_step = 1'b1;
        if (st.fill_end) begin
          state_next = after_nl;
        end
      end
      ST_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (st.fill_end) begin
          state_next = ST_EM_PLAIN;
        end
      end
      ST_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = ST_EM_PLAIN;
      end
      ST_EM_PLAIN: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_EM_CHAR_END: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_sel  = EM_CHAR;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_EM_CHAR: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_sel  = EM_CHAR;
          state_next    = ST_EM_CR;
        end
      end
      ST_EM_CR: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_sel  = EM_CR;
          state_next    = ST_EM_LF;
        end
      end
      ST_EM_LF: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_sel  = EM_LF;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_lf_ends_request, clk, rst, (state == ST_EM_LF) && st.out_free, state == ST_IDLE, "LF result did not close the request")

endmodule

@@ src/txcon_dp.sv @@
// Datapath for the text console: cursor, attribute, cell buffer, result register.
// Depends on txcon_pkg, txcon_ram and assert_macros.svh.
`include "assert_macros.svh"

module txcon_dp
  import txcon_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          st,
  input  logic [KIND_W-1:0]   kind,
  input  logic [CH_W-1:0]     char_code,
  input  logic [CH_W-1:0]     attr_value,
  input  logic [POS_W-1:0]    read_index,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                serial_valid,
  output logic [CH_W-1:0]     serial_byte,
  output logic [POS_W-1:0]    cursor_pos,
  output logic [CELL_W-1:0]   cell_value,
  output logic                last
);

  localparam int NCELLS   = ROWS * COLS;
  localparam int LAST_ROW = (ROWS - 1) * COLS;
  localparam int AW       = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam logic [POS_W-1:0] COLS_P     = POS_W'(COLS);
  localparam logic [POS_W-1:0] LAST_ROW_P = POS_W'(LAST_ROW);
  localparam logic [POS_W-1:0] LAST_CELL  = POS_W'(NCELLS - 1);
  localparam logic [POS_W:0]   NCELLS_X   = (POS_W + 1)'(NCELLS);

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [CH_W-1:0]   cur_attr;
  logic [POS_W-1:0]  ptr;
  logic              wpend;
  logic [POS_W-1:0]  waddr;
  logic [KIND_W-1:0] kind_q;
  logic [CH_W-1:0]   ch_q;
  logic [CH_W-1:0]   attr_q;
  logic [POS_W-1:0]  idx_q;
  logic [CELL_W-1:0] cell_q;

  logic [POS_W-1:0]  cursor_lin;
  logic              idx_ok;
  logic              cursor_ok;
  logic              waddr_ok;
  logic              ram_we;
  logic [POS_W-1:0]  ram_wa;
  logic [CELL_W-1:0] ram_wd;
  logic [POS_W-1:0]  ram_ra;
  logic [CELL_W-1:0] ram_rd;
  item_cls_t         cls;

  assign cursor_lin = POS_W'(row) * COLS_P + POS_W'(col);
  assign idx_ok     = {1'b0, idx_q} < NCELLS_X;
  assign cursor_ok  = {1'b0, cursor_lin} < NCELLS_X;
  assign waddr_ok   = waddr < LAST_ROW_P;

  always_comb begin
    case (kind_q)
      KIND_PUT:      cls = (ch_q == CHAR_NL) ? CLS_NEWLINE : CLS_PUT;
      KIND_NEWLINE:  cls = CLS_NEWLINE;
      KIND_CLEAR:    cls = CLS_CLEAR;
      KIND_SET_ATTR: cls = CLS_SET_ATTR;
      KIND_READ:     cls = CLS_READ;
      default:       cls = CLS_NONE;
    endcase
  end

  assign st.cls        = cls;
  assign st.wrap       = col == COL_W'(COLS - 1);
  assign st.bottom     = row == ROW_W'(ROWS - 1);
  assign st.scroll_end = ptr == LAST_ROW_P;
  assign st.fill_end   = ptr == LAST_CELL;
  assign st.out_free   = !result_valid || !result_stall;

  // Write port: a pending scroll copy wins; only one source is active per state.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = ptr;
    ram_wd = {cur_attr, CHAR_BLANK};
    if (wpend) begin
      ram_we = 1'b1;
      ram_wa = waddr;
      ram_wd = ram_rd;
    end else if (cmd.put_write) begin
      ram_we = 1'b1;
      ram_wa = cursor_lin;
      ram_wd = {cur_attr, ch_q};
    end else if (cmd.fill_step) begin
      ram_we = 1'b1;
    end
  end

  assign ram_ra = cmd.scroll_step ? (ptr + COLS_P) : idx_q;

  txcon_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa[AW-1:0]),
    .wdata (ram_wd),
    .raddr (ram_ra[AW-1:0]),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      cur_attr <= ATTR_RESET;
      ptr      <= '0;
      wpend    <= 1'b0;
    end else begin
      if (cmd.attr_load) begin
        cur_attr <= attr_q;
      end
      if (cmd.home) begin
        row <= '0;
        col <= '0;
      end else if (cmd.newline_step) begin
        col <= '0;
        if (!st.bottom) begin
          row <= row + ROW_W'(1);
        end
      end else if (cmd.col_inc) begin
        col <= col + COL_W'(1);
      end
      if (cmd.ptr_zero) begin
        ptr <= '0;
      end else if (cmd.fill_step && !st.fill_end) begin
        ptr <= ptr + POS_W'(1);
      end else if (cmd.scroll_step && !st.scroll_end) begin
        ptr <= ptr + POS_W'(1);
      end
      // The copy is written in the cycle after its read: remember where it lands.
      wpend <= cmd.scroll_step && !st.scroll_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scroll_step) begin
      waddr <= ptr;
    end
    if (cmd.load_item) begin
      kind_q <= kind;
      ch_q   <= char_code;
      attr_q <= attr_value;
      idx_q  <= read_index;
      cell_q <= '0;
    end else if (cmd.read_capture) begin
      cell_q <= idx_ok ? ram_rd : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      serial_valid <= cmd.emit_sel != EM_NONE;
      case (cmd.emit_sel)
        EM_CHAR: serial_byte <= ch_q;
        EM_CR:   serial_byte <= CHAR_CR;
        EM_LF:   serial_byte <= CHAR_NL;
        default: serial_byte <= '0;
      endcase
      cursor_pos <= cursor_lin;
      cell_value <= cell_q;
      last       <= cmd.emit_last;
    end
  end

  `ASSERT_CLK(a_cursor_in_buf, clk, rst, cursor_ok, "cursor left the cell buffer")
  `ASSERT_CLK(a_scroll_wr_range, clk, rst, !wpend || waddr_ok, "scroll copy aimed at bottom row")
  `ASSERT_NEXT(a_read_oob_zero, clk, rst, cmd.read_capture && !idx_ok, cell_q == '0, "out-of-range read returned data")

endmodule

@@ src/text_console_cell_writer_top.sv @@
// Text console cell writer: ROWS x COLS buffer of 16-bit cells (attribute high byte,
// character low byte) with cursor, current attribute and a serial mirror of each
// written character (CR then LF on a new line). After reset the block runs a
// clearing pass over all ROWS*COLS cells (2000 at the defaults) writing blank cells,
// during which item_stall is high. One request is handled at a time by a
// sequencer over a single-port-write, registered-read cell RAM. A newline on the
// bottom row adds a scroll that moves each row up, one cell copied per RAM cycle,
// then blanks the bottom row; a clear blanks every cell, homes the cursor. Results
// leave through a one-entry output register; a stall there holds the sequencer.
// Depends on txcon_pkg, txcon_ctrl and txcon_dp.
module text_console_cell_writer_top
  import txcon_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [CH_W-1:0]   char_code,
  input  logic [CH_W-1:0]   attr_value,
  input  logic [POS_W-1:0]  read_index,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              serial_valid,
  output logic [CH_W-1:0]   serial_byte,
  output logic [POS_W-1:0]  cursor_pos,
  output logic [CELL_W-1:0] cell_value,
  output logic              last
);

  dp_cmd_t    cmd;
  dp_status_t st;

  txcon_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  txcon_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .kind         (kind),
    .char_code    (char_code),
    .attr_value   (attr_value),
    .read_index   (read_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .serial_valid (serial_valid),
    .serial_byte  (serial_byte),
    .cursor_pos   (cursor_pos),
    .cell_value   (cell_value),
    .last         (last)
  );

endmodule
